[rtl/fpc_pkg.sv]
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and round function for the 28-bit Feistel PC cipher
// Holds the op and register codes, the pipeline stage record, the S-box and
// the Feistel round function used by every round cell.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  localparam int ROUNDS    = 8;
  localparam int HALF_W    = 14;
  localparam int WORD_W    = 2 * HALF_W;
  localparam int VALUE_W   = 32;
  localparam int KEY_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic [31:0] RF_C1 = 32'h9E37_79B9;
  localparam logic [31:0] RF_C2 = 32'h85EB_CA6B;
  localparam logic [31:0] RF_C3 = 32'hC2B2_AE35;

  typedef enum logic [1:0] {
    OP_ENCODE     = 2'd0,
    OP_DECODE     = 2'd1,
    OP_TRANSITION = 2'd2,
    OP_RESERVED   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEYS_0_1   = 3'd0,
    REG_KEYS_2_3   = 3'd1,
    REG_KEYS_4_5   = 3'd2,
    REG_KEYS_6_7   = 3'd3,
    REG_PRE_WHITE  = 3'd4,
    REG_POST_WHITE = 3'd5,
    REG_ENABLE     = 3'd6
  } cfg_reg_t;

  // One pipeline slot as it travels down the chain of cells.
  typedef struct packed {
    logic                vld;
    op_t                 op;
    logic [VALUE_W-1:0]  value;
    logic [WORD_W-1:0]   hint;
    logic [WORD_W-1:0]   word;
  } stage_t;

  localparam logic [3:0] SBOX [16] = '{
    4'h6, 4'hB, 4'h3, 4'h8, 4'hD, 4'h0, 4'hA, 4'hF,
    4'h2, 4'hC, 4'h5, 4'h1, 4'hE, 4'h9, 4'h7, 4'h4
  };

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

  // Round function; only the low half-width bits are ever consumed.
  function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] half,
                                                 input logic [KEY_W-1:0]  key);
    logic [31:0] x;
    logic [31:0] prod;
    x = {{(32-HALF_W){1'b0}}, half} ^ key;
    x[3:0] = SBOX[x[3:0]];
    x[7:4] = SBOX[x[7:4]];
    x = rotl32(x, 7) ^ RF_C1;
    prod = x * RF_C2;
    x = {16'h0000, prod[31:16]} ^ x;
    x = rotl32(x, 13) ^ RF_C3;
    x[11:8]  = SBOX[x[11:8]];
    x[15:12] = SBOX[x[15:12]];
    round_fn = x[HALF_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/feistel_pc_cipher_28bit_core.sv]
// ----------------------------------------------------------------------------
// feistel_pc_cipher_28bit_core: pipelined 28-bit Feistel PC cipher
// Encodes, decodes or steps an enciphered program counter through a chain
// of registered round cells: a decode chain, an advance stage, an encode
// chain.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_op, in_value, in_hint) takes
//   one transaction per cycle while in_stall is low. Every transaction
//   produces exactly one result transaction on out_valid / out_stall /
//   out_result, in order. A transaction passes through an entry register,
//   ROUNDS decode cells, the advance stage, ROUNDS encode cells and the
//   output register. Throughput is one transaction per cycle while the
//   output is not stalled, set by the single round per cell in each chain.
//   When the receiver stalls a waiting result, the whole chain holds and
//   in_stall is raised in the same cycle; bubbles in the chain do not hold
//   it. The configuration port is always ready; registers should be written
//   only while no transaction is in flight.
//   Synchronous reset empties the pipeline, clears all round keys and both
//   whitening masks, and sets enable to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module feistel_pc_cipher_28bit_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [1:0]                    in_op,
  input  wire logic [31:0]                   in_value,
  input  wire logic [27:0]                   in_hint,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [31:0]                   out_result,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [fpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpc_pkg::CFG_W-1:0]     cfg_data
);
  import fpc_pkg::*;

  logic [CFG_W-1:0]   rk_r [4];
  logic [WORD_W-1:0]  pre_wh_r;
  logic [WORD_W-1:0]  post_wh_r;
  logic               enable_r;
  logic [KEY_W-1:0]   key_w [8];

  logic               adv;
  stage_t             dchain [ROUNDS+1];
  stage_t             echain [ROUNDS+1];
  logic               entry_vld_r;
  stage_t             entry_r;
  logic               mid_vld_r;
  stage_t             mid_r;
  logic [WORD_W-1:0]  plain;
  logic [WORD_W-1:0]  next_pc;
  logic [WORD_W-1:0]  mid_word_nxt;
  logic               out_vld_r;
  logic [VALUE_W-1:0] out_result_r;
  op_t                out_op_r;
  logic [VALUE_W-1:0] result_nxt;
  stage_t             last;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        rk_r[i] <= '0;
      end
      pre_wh_r  <= '0;
      post_wh_r <= '0;
      enable_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEYS_0_1:   rk_r[0]   <= cfg_data;
        REG_KEYS_2_3:   rk_r[1]   <= cfg_data;
        REG_KEYS_4_5:   rk_r[2]   <= cfg_data;
        REG_KEYS_6_7:   rk_r[3]   <= cfg_data;
        REG_PRE_WHITE:  pre_wh_r  <= cfg_data[WORD_W-1:0];
        REG_POST_WHITE: post_wh_r <= cfg_data[WORD_W-1:0];
        REG_ENABLE:     enable_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key_w[2*i]   = rk_r[i][KEY_W-1:0];
      key_w[2*i+1] = rk_r[i][CFG_W-1:KEY_W];
    end
  end

  // ---------------- flow control ----------------
  // The chain moves as one; it holds only while a finished result is refused.
  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !adv;

  // ---------------- entry register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= 1'b0;
    end else if (adv) begin
      entry_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry_r.vld   <= in_valid;
      entry_r.op    <= op_t'(in_op);
      entry_r.value <= in_value;
      entry_r.hint  <= in_hint;
      entry_r.word  <= in_value[WORD_W-1:0] ^ post_wh_r;
    end
  end

  always_comb begin
    dchain[0]     = entry_r;
    dchain[0].vld = entry_vld_r;
  end

  // ---------------- decode chain: keys in reverse order ----------------
  for (genvar j = 0; j < ROUNDS; j++) begin : g_dec
    fpc_round_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .dec     (1'b1),
      .key     (key_w[3'(ROUNDS-1-j)]),
      .stage_i (dchain[j]),
      .stage_o (dchain[j+1])
    );
  end

  // ---------------- advance stage ----------------
  assign plain   = dchain[ROUNDS].word ^ pre_wh_r;
  assign next_pc = (dchain[ROUNDS].hint == '0) ? (plain + WORD_W'(1)) : dchain[ROUNDS].hint;

  always_comb begin
    case (dchain[ROUNDS].op)
      OP_ENCODE:     mid_word_nxt = dchain[ROUNDS].value[WORD_W-1:0] ^ pre_wh_r;
      OP_TRANSITION: mid_word_nxt = next_pc ^ pre_wh_r;
      default:       mid_word_nxt = plain;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
    end else if (adv) begin
      mid_vld_r <= dchain[ROUNDS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r.vld   <= dchain[ROUNDS].vld;
      mid_r.op    <= dchain[ROUNDS].op;
      mid_r.value <= dchain[ROUNDS].value;
      mid_r.hint  <= dchain[ROUNDS].hint;
      mid_r.word  <= mid_word_nxt;
    end
  end

  always_comb begin
    echain[0]     = mid_r;
    echain[0].vld = mid_vld_r;
  end

  // ---------------- encode chain ----------------
  for (genvar j = 0; j < ROUNDS; j++) begin : g_enc
    fpc_round_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .dec     (1'b0),
      .key     (key_w[3'(j)]),
      .stage_i (echain[j]),
      .stage_o (echain[j+1])
    );
  end

  // ---------------- output register ----------------
  assign last = echain[ROUNDS];

  always_comb begin
    case (last.op)
      OP_ENCODE: begin
        result_nxt = enable_r ? {{(VALUE_W-WORD_W){1'b0}}, last.word ^ post_wh_r}
                              : last.value;
      end
      OP_DECODE: begin
        result_nxt = enable_r ? {{(VALUE_W-WORD_W){1'b0}}, last.word} : last.value;
      end
      OP_TRANSITION: begin
        result_nxt = {{(VALUE_W-WORD_W){1'b0}}, last.word ^ post_wh_r};
      end
      default: begin
        result_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= result_nxt;
      out_op_r     <= last.op;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_result = out_result_r;

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> dchain[0].vld)
    else $error("accepted transaction did not enter the chain");

  a_reserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_op_r == OP_RESERVED) |-> (out_result == '0))
    else $error("reserved op produced a nonzero result");

  a_transition_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_op_r == OP_TRANSITION) |-> (out_result[VALUE_W-1:WORD_W] == '0))
    else $error("transition result exceeds the cipher width");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (mid_vld_r == $past(mid_vld_r) && entry_vld_r == $past(entry_vld_r)))
    else $error("chain moved while the output was stalled");

endmodule

`default_nettype wire

[rtl/fpc_round_cell.sv]
// ----------------------------------------------------------------------------
// fpc_round_cell: one registered Feistel round
// Applies a forward or inverse round to the slot it receives when the op
// calls for this direction, otherwise passes the slot through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_round_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     dec,
  input  wire logic [fpc_pkg::KEY_W-1:0] key,
  input  wire fpc_pkg::stage_t          stage_i,
  output fpc_pkg::stage_t               stage_o
);
  import fpc_pkg::*;

  logic                 vld_r;
  stage_t               pay_r;
  logic                 active;
  logic [HALF_W-1:0]    left;
  logic [HALF_W-1:0]    right;
  logic [HALF_W-1:0]    f_out;
  logic [WORD_W-1:0]    word_nxt;

  assign left  = stage_i.word[WORD_W-1:HALF_W];
  assign right = stage_i.word[HALF_W-1:0];

  always_comb begin
    if (dec) begin
      active = (stage_i.op == OP_DECODE) || (stage_i.op == OP_TRANSITION);
    end else begin
      active = (stage_i.op == OP_ENCODE) || (stage_i.op == OP_TRANSITION);
    end
  end

  // The inverse round is the forward round with the halves swapped.
  assign f_out = round_fn(dec ? left : right, key);

  always_comb begin
    if (!active) begin
      word_nxt = stage_i.word;
    end else if (dec) begin
      word_nxt = {right ^ f_out, left};
    end else begin
      word_nxt = {right, left ^ f_out};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= stage_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay_r.vld   <= stage_i.vld;
      pay_r.op    <= stage_i.op;
      pay_r.value <= stage_i.value;
      pay_r.hint  <= stage_i.hint;
      pay_r.word  <= word_nxt;
    end
  end

  always_comb begin
    stage_o     = pay_r;
    stage_o.vld = vld_r;
  end

endmodule

`default_nettype wire
